>>> hdl/mhjs_pkg.sv
// Shared types, sizes and helper function of the min-heap job scheduler.
// No dependencies; used by mhjs_cell and min_heap_job_scheduler.
`default_nettype none

package mhjs_pkg;

   localparam int LEVELS     = 7;
   localparam int ROWS_MAX   = 16;
   localparam int ROW_W      = 4;
   localparam int OFFSET_W   = 5;
   localparam int LEVEL_W    = 3;
   localparam int COUNT_W    = 7;
   localparam int INDEX_W    = 6;
   localparam int TIME_W     = 64;
   localparam int DURATION_W = 32;
   localparam int ADDR_W     = 3;
   localparam int DATA_W     = 32;

   localparam logic [COUNT_W-1:0] WORKERS_MIN = 7'd1;
   localparam logic [COUNT_W-1:0] WORKERS_MAX = 7'd64;

   localparam logic REG_WORKER_COUNT = 1'b0;

   typedef struct packed {
      logic [TIME_W-1:0]  finish;
      logic [INDEX_W-1:0] worker;
   } entry_type;

   typedef struct packed {
      logic                valid;
      logic [OFFSET_W-1:0] offset;
      entry_type           entry;
   } move_type;

   function automatic logic entry_less(entry_type a, entry_type b);
      logic result;
      if (a.finish != b.finish) begin
         result = a.finish < b.finish;
      end else begin
         result = a.worker < b.worker;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

>>> hdl/mhjs_cell.sv
// One heap level of the scheduler: holds the level's entries in pairs of siblings
// and performs one compare-and-swap step of the sift-down. Depends on mhjs_pkg.
`default_nettype none

module mhjs_cell (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            clear,
   input  wire [mhjs_pkg::LEVEL_W-1:0]    cell_level,
   input  wire [mhjs_pkg::COUNT_W-1:0]    worker_count,
   input  mhjs_pkg::move_type             tok_in,
   input  mhjs_pkg::move_type             down_wr,
   output mhjs_pkg::move_type             up_wr,
   output mhjs_pkg::move_type             tok_out,
   output logic                           stop
);

   mhjs_pkg::entry_type               data_ff [mhjs_pkg::ROWS_MAX][2];
   logic [mhjs_pkg::ROWS_MAX-1:0][1:0] valid_ff;
   mhjs_pkg::move_type                tok_out_ff;
   mhjs_pkg::move_type                tok_out_in;

   logic [mhjs_pkg::OFFSET_W-1:0] parent_mask;
   logic [mhjs_pkg::OFFSET_W-1:0] parent;
   logic [mhjs_pkg::ROW_W-1:0]    row_mask;
   logic [mhjs_pkg::ROW_W-1:0]    row;
   logic [mhjs_pkg::ROW_W-1:0]    wr_row;
   logic [mhjs_pkg::COUNT_W-1:0]  base_idx;
   logic [mhjs_pkg::COUNT_W-1:0]  left_idx;
   logic [mhjs_pkg::COUNT_W-1:0]  right_idx;
   mhjs_pkg::entry_type           left;
   mhjs_pkg::entry_type           right;
   mhjs_pkg::entry_type           pick;
   logic                          left_exists;
   logic                          right_exists;
   logic                          right_better;
   logic                          child_wins;

   assign parent_mask = mhjs_pkg::OFFSET_W'((6'd1 << (cell_level - 3'd1)) - 6'd1);
   assign parent      = tok_in.offset & parent_mask;
   assign row_mask    = parent_mask[mhjs_pkg::ROW_W-1:0];
   assign row         = parent[mhjs_pkg::ROW_W-1:0];
   assign wr_row      = down_wr.offset[mhjs_pkg::OFFSET_W-1:1] & row_mask;
   assign base_idx    = mhjs_pkg::COUNT_W'((8'd1 << cell_level) - 8'd1);
   assign left_idx    = base_idx + {1'b0, parent, 1'b0};
   assign right_idx   = left_idx + 7'd1;

   always_comb begin
      if (valid_ff[row][0]) begin
         left = data_ff[row][0];
      end else begin
         left = '{finish: '0, worker: left_idx[mhjs_pkg::INDEX_W-1:0]};
      end
      if (valid_ff[row][1]) begin
         right = data_ff[row][1];
      end else begin
         right = '{finish: '0, worker: right_idx[mhjs_pkg::INDEX_W-1:0]};
      end
      left_exists  = left_idx < worker_count;
      right_exists = right_idx < worker_count;
      right_better = right_exists && mhjs_pkg::entry_less(right, left);
      pick         = right_better ? right : left;
      child_wins   = left_exists && mhjs_pkg::entry_less(pick, tok_in.entry);

      up_wr.valid  = tok_in.valid;
      up_wr.offset = tok_in.offset;
      up_wr.entry  = child_wins ? pick : tok_in.entry;
      stop         = tok_in.valid && !child_wins;

      tok_out_in.valid  = tok_in.valid && child_wins;
      tok_out_in.offset = {row, right_better};
      tok_out_in.entry  = tok_in.entry;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (down_wr.valid) begin
         valid_ff[wr_row][down_wr.offset[0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (down_wr.valid) begin
         data_ff[wr_row][down_wr.offset[0]] <= down_wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out_ff <= '0;
      end else begin
         tok_out_ff <= tok_out_in;
      end
   end

   assign tok_out = tok_out_ff;

endmodule

`default_nettype wire

>>> hdl/min_heap_job_scheduler.sv
// Top level of the min-heap job scheduler: root register, configuration port and
// the row of heap-level cells. Depends on mhjs_pkg and mhjs_cell.
//
// A job word is taken on req_job_duration at a clock edge where start is high and
// busy is low. The next cycle rsp_valid pulses for one cycle with rsp_worker_index
// and rsp_start_time of the worker that becomes free first; the receiver cannot
// stall this strobe. The chosen worker's finish time then sifts down the heap,
// one level per cycle through the chain of level cells, with busy held high.
// A job passes through acceptance, one compare step for each heap level the sift
// examines, up to six levels for 64 workers, and a write of the bottom level when
// the sift reaches it. The worker_count register answers at APB byte address 0
// and every address with paddr[2] low. Writing it clamps pwdata[6:0] to 1..64 and
// restarts the heap with every finish time at zero and the workers in index
// order. Reset does the same with one worker. Addresses with bit 2 high read as
// zero and ignore writes. Write it only while busy is low; this is not enforced.
`default_nettype none

module min_heap_job_scheduler (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [mhjs_pkg::DURATION_W-1:0]       req_job_duration,
   output logic                                 rsp_valid,
   output logic [mhjs_pkg::INDEX_W-1:0]         rsp_worker_index,
   output logic [mhjs_pkg::TIME_W-1:0]          rsp_start_time,
   input  wire                                  psel,
   input  wire                                  penable,
   input  wire                                  pwrite,
   input  wire [mhjs_pkg::ADDR_W-1:0]           paddr,
   input  wire [mhjs_pkg::DATA_W-1:0]           pwdata,
   output logic [mhjs_pkg::DATA_W-1:0]          prdata,
   output logic                                 pready
);

   localparam int LAST = mhjs_pkg::LEVELS - 1;

   logic [mhjs_pkg::COUNT_W-1:0]  worker_count_ff;
   logic [mhjs_pkg::COUNT_W-1:0]  worker_count_in;
   mhjs_pkg::entry_type           root_ff;
   logic                          busy_ff;
   logic                          rsp_valid_ff;
   logic [mhjs_pkg::INDEX_W-1:0]  rsp_index_ff;
   logic [mhjs_pkg::TIME_W-1:0]   rsp_start_ff;
   mhjs_pkg::move_type            tok1_ff;
   mhjs_pkg::move_type            tok1_in;

   mhjs_pkg::move_type            tok_lvl [1:mhjs_pkg::LEVELS];
   mhjs_pkg::move_type            wr_up   [1:LAST];
   mhjs_pkg::move_type            wr_down [1:LAST];
   logic [LAST:1]                 stop;

   logic                          accept;
   logic                          cfg_wr;
   logic                          done;
   logic [mhjs_pkg::COUNT_W-1:0]  cfg_value;

   assign pready    = 1'b1;
   assign accept    = start && !busy_ff;
   assign cfg_wr    = psel && penable && pwrite && (paddr[2] == mhjs_pkg::REG_WORKER_COUNT);
   assign cfg_value = pwdata[mhjs_pkg::COUNT_W-1:0];
   assign done      = (|stop) || tok_lvl[mhjs_pkg::LEVELS].valid;

   always_comb begin
      if (cfg_value < mhjs_pkg::WORKERS_MIN) begin
         worker_count_in = mhjs_pkg::WORKERS_MIN;
      end else if (cfg_value > mhjs_pkg::WORKERS_MAX) begin
         worker_count_in = mhjs_pkg::WORKERS_MAX;
      end else begin
         worker_count_in = cfg_value;
      end
   end

   always_comb begin
      if (paddr[2] == mhjs_pkg::REG_WORKER_COUNT) begin
         prdata = {{(mhjs_pkg::DATA_W - mhjs_pkg::COUNT_W){1'b0}}, worker_count_ff};
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= mhjs_pkg::WORKERS_MIN;
      end else if (cfg_wr) begin
         worker_count_ff <= worker_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         root_ff <= '0;
      end else if (wr_up[1].valid) begin
         root_ff <= wr_up[1].entry;
      end
   end

   always_comb begin
      tok1_in.valid        = accept;
      tok1_in.offset       = '0;
      tok1_in.entry.finish = root_ff.finish
                           + {{(mhjs_pkg::TIME_W - mhjs_pkg::DURATION_W){1'b0}},
                              req_job_duration};
      tok1_in.entry.worker = root_ff.worker;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tok1_ff      <= '0;
      end else begin
         rsp_valid_ff <= accept;
         tok1_ff      <= tok1_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_index_ff <= root_ff.worker;
         rsp_start_ff <= root_ff.finish;
      end
   end

   assign tok_lvl[1] = tok1_ff;

   for (genvar g = 1; g <= LAST; g++) begin : g_level
      if (g < LAST) begin : g_mid
         assign wr_down[g] = wr_up[g+1];
      end else begin : g_end
         assign wr_down[g] = tok_lvl[mhjs_pkg::LEVELS];
      end

      mhjs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .clear        (cfg_wr),
         .cell_level   (mhjs_pkg::LEVEL_W'(g)),
         .worker_count (worker_count_ff),
         .tok_in       (tok_lvl[g]),
         .down_wr      (wr_down[g]),
         .up_wr        (wr_up[g]),
         .tok_out      (tok_lvl[g+1]),
         .stop         (stop[g])
      );
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_worker_index = rsp_index_ff;
   assign rsp_start_time   = rsp_start_ff;

endmodule

`default_nettype wire
